FILE: src/fc12_pkg.sv
package fc12_pkg;

   localparam int OffsetW  = 13;
   localparam int ByteW    = 8;
   localparam int ClusW    = 12;
   localparam int AddrW    = 32;
   localparam int StatusW  = 2;

   localparam int CsrIdxW  = 3;
   localparam int CsrDataW = 16;

   localparam int BpsW     = 13;
   localparam int SpcW     = 8;
   localparam int RsvW     = 16;
   localparam int CopiesW  = 8;
   localparam int TsecW    = 16;
   localparam int RootEntW = 16;

   // root directory bytes = entries * 32
   localparam int DirEntShift = 5;
   localparam int NumW        = RootEntW + DirEntShift;

   localparam int FatSecW  = CopiesW + TsecW;
   localparam int ClBytesW = SpcW + BpsW;
   localparam int SumW     = 25;
   localparam int FirstW   = BpsW + SumW;
   localparam int ProdW    = ClusW + ClBytesW;
   localparam int AddrSumW = FirstW + 1;

   localparam logic ACTION_LOAD   = 1'b0;
   localparam logic ACTION_LOOKUP = 1'b1;

   localparam logic [CsrIdxW-1:0] CSR_BYTES_PER_SECTOR    = 3'd0;
   localparam logic [CsrIdxW-1:0] CSR_SECTORS_PER_CLUSTER = 3'd1;
   localparam logic [CsrIdxW-1:0] CSR_RESERVED_SECTORS    = 3'd2;
   localparam logic [CsrIdxW-1:0] CSR_TABLE_COPIES        = 3'd3;
   localparam logic [CsrIdxW-1:0] CSR_TABLE_SECTORS       = 3'd4;
   localparam logic [CsrIdxW-1:0] CSR_ROOT_ENTRIES        = 3'd5;

   localparam logic [BpsW-1:0]     RST_BYTES_PER_SECTOR    = 13'd512;
   localparam logic [SpcW-1:0]     RST_SECTORS_PER_CLUSTER = 8'd1;
   localparam logic [RsvW-1:0]     RST_RESERVED_SECTORS    = 16'd1;
   localparam logic [CopiesW-1:0]  RST_TABLE_COPIES        = 8'd2;
   localparam logic [TsecW-1:0]    RST_TABLE_SECTORS       = 16'd9;
   localparam logic [RootEntW-1:0] RST_ROOT_ENTRIES        = 16'd224;

   localparam logic [StatusW-1:0] STATUS_CONTINUE = 2'd0;
   localparam logic [StatusW-1:0] STATUS_LAST     = 2'd1;
   localparam logic [StatusW-1:0] STATUS_BAD      = 2'd2;
   localparam logic [StatusW-1:0] STATUS_NO_DATA  = 2'd3;

   localparam logic [ClusW-1:0] ENTRY_BAD      = 12'hFF7;
   localparam logic [ClusW-1:0] ENTRY_LAST_MIN = 12'hFF8;
   localparam logic [ClusW-1:0] FIRST_CLUSTER  = 12'd2;
   localparam logic [AddrW-1:0] ADDR_MAX       = 32'hFFFF_FFFF;

   typedef struct packed {
      logic               action;
      logic [OffsetW-1:0] table_offset;
      logic [ByteW-1:0]   table_byte;
      logic [ClusW-1:0]   cluster;
   } fc12_req_type;

   typedef struct packed {
      logic [ClusW-1:0]   next_cluster;
      logic [AddrW-1:0]   data_address;
      logic [StatusW-1:0] status;
   } fc12_rsp_type;

   typedef struct packed {
      logic geom_start;
      logic geom_sum;
      logic geom_first;
      logic mem_wr;
      logic lookup_start;
      logic read_hi;
      logic rsp_load;
   } fc12_cmd_type;

   typedef struct packed {
      logic div_done;
   } fc12_sts_type;

endpackage

FILE: src/fc12_div.sv
module fc12_div (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [fc12_pkg::NumW-1:0] dividend,
   input  logic [fc12_pkg::BpsW-1:0] divisor,
   output logic                     done,
   output logic [fc12_pkg::NumW-1:0] quotient,
   output logic                     rem_nz
);
   import fc12_pkg::*;

   localparam int CntW = $clog2(NumW + 1);

   logic [BpsW-1:0] rem_ff;
   logic [BpsW-1:0] rem_in;
   logic [NumW-1:0] quo_ff;
   logic [NumW-1:0] quo_in;
   logic [CntW-1:0] cnt_ff;
   logic            busy_ff;
   logic            done_ff;
   logic [BpsW:0]   shifted;
   logic [BpsW:0]   diff;
   logic            fits;

   // one restoring step per cycle, quotient bits shift in from the bottom
   always_comb begin
      shifted = {rem_ff, quo_ff[NumW-1]};
      diff    = shifted - {1'b0, divisor};
      fits    = (shifted >= {1'b0, divisor});
      rem_in  = fits ? diff[BpsW-1:0] : shifted[BpsW-1:0];
      quo_in  = {quo_ff[NumW-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= CntW'(NumW);
         rem_ff  <= '0;
         quo_ff  <= dividend;
      end else if (busy_ff) begin
         rem_ff  <= rem_in;
         quo_ff  <= quo_in;
         cnt_ff  <= cnt_ff - CntW'(1);
         done_ff <= (cnt_ff == CntW'(1));
         busy_ff <= (cnt_ff != CntW'(1));
      end else begin
         done_ff <= 1'b0;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
   assign rem_nz   = (rem_ff != '0);

endmodule

FILE: src/fc12_dp.sv
module fc12_dp #(
   parameter int TABLE_BYTES = 6144
) (
   input  logic                          clock,
   input  logic                          reset,
   input  fc12_pkg::fc12_cmd_type        cmd,
   output fc12_pkg::fc12_sts_type        sts,
   input  fc12_pkg::fc12_req_type        req_item,
   input  logic                          csr_write,
   input  logic [fc12_pkg::CsrIdxW-1:0]  csr_index,
   input  logic [fc12_pkg::CsrDataW-1:0] csr_data,
   output fc12_pkg::fc12_rsp_type        rsp_item
);
   import fc12_pkg::*;

   localparam int MemAW = (TABLE_BYTES > 1) ? $clog2(TABLE_BYTES) : 1;
   localparam int LimW  = OffsetW + 1;
   localparam logic [LimW-1:0] TableLimit = LimW'(TABLE_BYTES);

   // geometry registers
   logic [BpsW-1:0]     bps_ff;
   logic [SpcW-1:0]     spc_ff;
   logic [RsvW-1:0]     rsv_ff;
   logic [CopiesW-1:0]  copies_ff;
   logic [TsecW-1:0]    tsec_ff;
   logic [RootEntW-1:0] root_ent_ff;

   // derived geometry
   logic [FatSecW-1:0]  fat_sec_ff;
   logic [ClBytesW-1:0] cl_bytes_ff;
   logic [SumW-1:0]     sum_ff;
   logic [SumW-1:0]     sum_in;
   logic [SumW-1:0]     root_sec;
   logic [FirstW-1:0]   first_ff;

   logic [NumW-1:0]     div_quo;
   logic                div_rem_nz;
   logic                div_done;

   // lookup state
   logic [ByteW-1:0]    mem [TABLE_BYTES];
   logic [ByteW-1:0]    q_ff;
   logic [OffsetW-1:0]  mem_addr;
   logic [MemAW-1:0]    mem_idx;
   logic                mem_ok;
   logic [ClusW-1:0]    clus_ff;
   logic                lo_ok_ff;
   logic                hi_ok_ff;
   logic [ByteW-1:0]    byte_lo_ff;
   logic [ByteW-1:0]    byte_hi;
   logic [ClusW-1:0]    clus_m2;
   logic [ProdW-1:0]    prod;
   logic [ProdW-1:0]    prod_ff;
   logic [2*ByteW-1:0]  pair;
   logic [ClusW-1:0]    entry;
   logic [AddrSumW-1:0] addr_sum;
   logic [AddrW-1:0]    addr_sat;
   logic                no_data;
   fc12_rsp_type        rsp_in;
   fc12_rsp_type        rsp_ff;

   function automatic logic [OffsetW-1:0] pair_pos(input logic [ClusW-1:0] clus);
      pair_pos = OffsetW'(clus) + OffsetW'(clus[ClusW-1:1]);
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         bps_ff      <= RST_BYTES_PER_SECTOR;
         spc_ff      <= RST_SECTORS_PER_CLUSTER;
         rsv_ff      <= RST_RESERVED_SECTORS;
         copies_ff   <= RST_TABLE_COPIES;
         tsec_ff     <= RST_TABLE_SECTORS;
         root_ent_ff <= RST_ROOT_ENTRIES;
      end else if (csr_write) begin
         case (csr_index)
            CSR_BYTES_PER_SECTOR:    bps_ff      <= csr_data[BpsW-1:0];
            CSR_SECTORS_PER_CLUSTER: spc_ff      <= csr_data[SpcW-1:0];
            CSR_RESERVED_SECTORS:    rsv_ff      <= csr_data[RsvW-1:0];
            CSR_TABLE_COPIES:        copies_ff   <= csr_data[CopiesW-1:0];
            CSR_TABLE_SECTORS:       tsec_ff     <= csr_data[TsecW-1:0];
            CSR_ROOT_ENTRIES:        root_ent_ff <= csr_data[RootEntW-1:0];
            default: ;
         endcase
      end
   end

   fc12_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.geom_start),
      .dividend ({root_ent_ff, {DirEntShift{1'b0}}}),
      .divisor  (bps_ff),
      .done     (div_done),
      .quotient (div_quo),
      .rem_nz   (div_rem_nz)
   );

   assign sts.div_done = div_done;

   // root sectors round up; a zero sector size drops the term
   always_comb begin
      root_sec = (bps_ff == '0) ? '0 : SumW'(div_quo) + SumW'(div_rem_nz);
      sum_in   = SumW'(rsv_ff) + SumW'(fat_sec_ff) + root_sec;
   end

   always_ff @(posedge clock) begin
      if (cmd.geom_start) begin
         fat_sec_ff  <= FatSecW'(copies_ff) * FatSecW'(tsec_ff);
         cl_bytes_ff <= ClBytesW'(spc_ff) * ClBytesW'(bps_ff);
      end
      if (cmd.geom_sum) begin
         sum_ff <= sum_in;
      end
      if (cmd.geom_first) begin
         first_ff <= FirstW'(bps_ff) * FirstW'(sum_ff);
      end
   end

   // single table port: request side on accept, high byte of the pair next
   always_comb begin
      if (cmd.read_hi) begin
         mem_addr = pair_pos(clus_ff) + OffsetW'(1);
      end else if (cmd.mem_wr) begin
         mem_addr = req_item.table_offset;
      end else begin
         mem_addr = pair_pos(req_item.cluster);
      end
      mem_ok  = ({1'b0, mem_addr} < TableLimit);
      mem_idx = MemAW'(mem_addr);
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_wr && mem_ok) begin
         mem[mem_idx] <= req_item.table_byte;
      end
      if ((cmd.lookup_start || cmd.read_hi) && mem_ok) begin
         q_ff <= mem[mem_idx];
      end
   end

   assign clus_m2 = clus_ff - FIRST_CLUSTER;
   assign prod    = ProdW'(clus_m2) * ProdW'(cl_bytes_ff);

   always_ff @(posedge clock) begin
      if (cmd.lookup_start) begin
         clus_ff  <= req_item.cluster;
         lo_ok_ff <= mem_ok;
      end
      if (cmd.read_hi) begin
         hi_ok_ff   <= mem_ok;
         byte_lo_ff <= lo_ok_ff ? q_ff : '0;
         prod_ff    <= prod;
      end
   end

   // bytes beyond the table read as zero
   always_comb begin
      byte_hi  = hi_ok_ff ? q_ff : '0;
      pair     = {byte_hi, byte_lo_ff};
      entry    = clus_ff[0] ? pair[2*ByteW-1:4] : pair[ClusW-1:0];
      addr_sum = AddrSumW'(first_ff) + AddrSumW'(prod_ff);
      addr_sat = (addr_sum[AddrSumW-1:AddrW] != '0) ? ADDR_MAX : addr_sum[AddrW-1:0];
      no_data  = (clus_ff < FIRST_CLUSTER) || (clus_ff >= ENTRY_LAST_MIN);
      rsp_in.next_cluster = entry;
      if (no_data) begin
         rsp_in.data_address = '0;
         rsp_in.status       = STATUS_NO_DATA;
      end else begin
         rsp_in.data_address = addr_sat;
         if (entry == ENTRY_BAD) begin
            rsp_in.status = STATUS_BAD;
         end else if (entry >= ENTRY_LAST_MIN) begin
            rsp_in.status = STATUS_LAST;
         end else begin
            rsp_in.status = STATUS_CONTINUE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_item = rsp_ff;

endmodule

FILE: src/fc12_ctrl.sv
module fc12_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_action,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  logic                   csr_write,
   input  fc12_pkg::fc12_sts_type sts,
   output fc12_pkg::fc12_cmd_type cmd
);
   import fc12_pkg::*;

   typedef enum logic [2:0] {
      ST_GEOM_START,
      ST_GEOM_DIV,
      ST_GEOM_SUM,
      ST_GEOM_FIRST,
      ST_IDLE,
      ST_READ_HI,
      ST_FINISH
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      slot_free;
   logic      accept;

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == ST_IDLE) || ((state_ff == ST_FINISH) && slot_free));
   assign accept    = req_valid && !req_stall;

   always_comb begin
      cmd              = '0;
      cmd.geom_start   = (state_ff == ST_GEOM_START);
      cmd.geom_sum     = (state_ff == ST_GEOM_SUM);
      cmd.geom_first   = (state_ff == ST_GEOM_FIRST);
      cmd.mem_wr       = accept && (req_action == ACTION_LOAD);
      cmd.lookup_start = accept && (req_action == ACTION_LOOKUP);
      cmd.read_hi      = (state_ff == ST_READ_HI);
      cmd.rsp_load     = (state_ff == ST_FINISH) && slot_free;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_GEOM_START: state_in = ST_GEOM_DIV;
         ST_GEOM_DIV: begin
            if (sts.div_done) state_in = ST_GEOM_SUM;
         end
         ST_GEOM_SUM:   state_in = ST_GEOM_FIRST;
         ST_GEOM_FIRST: state_in = ST_IDLE;
         ST_IDLE: begin
            if (cmd.lookup_start) state_in = ST_READ_HI;
         end
         ST_READ_HI:    state_in = ST_FINISH;
         ST_FINISH: begin
            // hand off the result and take the next item in the same cycle
            if (slot_free) state_in = cmd.lookup_start ? ST_READ_HI : ST_IDLE;
         end
         default:       state_in = ST_GEOM_START;
      endcase
      // any register write reruns the geometry setup
      if (csr_write) state_in = ST_GEOM_START;
   end

   always_comb begin
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_GEOM_START;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: src/fat12_cluster_chain_step.sv
// FAT12 cluster chain step. Load items write one byte of the allocation table
// into on-chip memory as they are accepted; lookup items read the 12-bit
// entry of a cluster and return the next cluster, the saturated byte address
// of the cluster's data and a status code. A lookup occupies the block through
// the two reads of the entry's byte pair from the single-port table memory;
// the finished result sits in an output register, so the next item is taken
// while it waits. After reset and after every register write the block derives
// the data-area geometry (a bit-serial divide for the root directory size, then
// a sum step and a multiply step) and stalls items meanwhile. Table bytes read
// by a lookup must have been loaded first.
module fat12_cluster_chain_step #(
   parameter int TABLE_BYTES = 6144
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  fc12_pkg::fc12_req_type        req_item,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output fc12_pkg::fc12_rsp_type        rsp_item,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [fc12_pkg::CsrIdxW-1:0]  csr_index,
   input  logic [fc12_pkg::CsrDataW-1:0] csr_data
);
   import fc12_pkg::*;

   fc12_cmd_type cmd;
   fc12_sts_type sts;
   logic         csr_write;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   fc12_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_item.action),
      .req_stall  (req_stall),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .csr_write  (csr_write),
      .sts        (sts),
      .cmd        (cmd)
   );

   fc12_dp #(
      .TABLE_BYTES (TABLE_BYTES)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_item  (req_item),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_item  (rsp_item)
   );

   // the high byte read always follows a lookup, so no item can enter then
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && (req_item.action == ACTION_LOOKUP)) |=> req_stall)
      else $error("item accepted during the second table read");

   // geometry is rebuilt after a register write before any item enters
   assert property (@(posedge clock) disable iff (reset)
      (csr_valid && csr_ready) |=> req_stall)
      else $error("item accepted before geometry setup");

   // a result only appears after the table reads of a lookup
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid && $past(!rsp_valid) && !$past(reset)) ##1 rsp_valid
         |-> $past(req_stall, 2))
      else $error("result without a preceding table read");

endmodule
